/* rtl/core/ipfp_pkg.sv */
package ipfp_pkg;

    localparam logic [15:0] MTU_RESET      = 16'd1500;
    localparam logic [15:0] MTU_FLOOR      = 16'd1088;
    localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;
    localparam logic [13:0] OFFSET_MAX     = 14'd8191;
    localparam int          MAX_FRAGMENTS  = 64;
    localparam int          FRAG_SHIFT     = $clog2(MAX_FRAGMENTS);
    localparam int          QUEUE_DEPTH    = 2;
    localparam int          QUEUE_PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int          QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_PASS = 2'd0,
        ST_FRAG = 2'd1,
        ST_DF   = 2'd2,
        ST_OVF  = 2'd3
    } status_t;

    // classified datagram handed from front to back
    typedef struct packed {
        status_t     status;
        logic [12:0] offset;
        logic        mf;
        logic        df;
        logic [15:0] total_length;
        logic [3:0]  hw;
        logic [3:0]  rhw;
        logic [15:0] datalen;
        logic [15:0] piece;
    } ipfp_desc_t;

endpackage

/* rtl/core/ipfp_front.sv */
module ipfp_front
    import ipfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] total_length,
    input  logic [3:0]  header_words,
    input  logic [15:0] frag_word,
    input  logic [3:0]  reduced_header_words,
    input  logic        queue_full,
    output logic        push,
    output ipfp_desc_t  push_desc
);

    logic [15:0] mtu_reg;
    logic        valid_reg;
    logic [15:0] tl_reg;
    logic [3:0]  hw_reg;
    logic [15:0] fw_reg;
    logic [3:0]  rhw_reg;

    logic                   accept;
    logic [3:0]             hw_c;
    logic [3:0]             rhw_lo;
    logic [3:0]             rhw_c;
    logic [15:0]            mtu_c;
    logic [15:0]            hbytes;
    logic [15:0]            datalen;
    logic [15:0]            piece;
    logic [13:0]            end_offset;
    logic [15+FRAG_SHIFT:0] max_data;
    status_t                status;

    assign busy   = valid_reg && queue_full;
    assign accept = start && !busy;
    assign push   = valid_reg && !queue_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mtu_reg   <= MTU_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                mtu_reg <= cfg_write_data;
            end
            if (accept)
            begin
                valid_reg <= 1'b1;
            end
            else if (push)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tl_reg  <= total_length;
            hw_reg  <= header_words;
            fw_reg  <= frag_word;
            rhw_reg <= reduced_header_words;
        end
    end

    always_comb
    begin
        hw_c   = (hw_reg < MIN_HDR_WORDS) ? MIN_HDR_WORDS : hw_reg;
        rhw_lo = (rhw_reg < MIN_HDR_WORDS) ? MIN_HDR_WORDS : rhw_reg;
        rhw_c  = (rhw_lo > hw_c) ? hw_c : rhw_lo;
        mtu_c  = (mtu_reg < MTU_FLOOR) ? MTU_FLOOR : mtu_reg;
        hbytes = {10'd0, hw_c, 2'b00};
        datalen = tl_reg - hbytes;
        piece   = (mtu_c - hbytes) & ~16'd7;
        end_offset = {1'b0, fw_reg[12:0]} + {1'b0, datalen[15:3]};
        max_data   = {{FRAG_SHIFT{1'b0}}, piece} << FRAG_SHIFT;

        if (tl_reg <= mtu_c)
        begin
            status = ST_PASS;
        end
        else if (fw_reg[14])
        begin
            status = ST_DF;
        end
        else if ((end_offset > OFFSET_MAX) || ({{FRAG_SHIFT{1'b0}}, datalen} > max_data))
        begin
            status = ST_OVF;
        end
        else
        begin
            status = ST_FRAG;
        end

        push_desc.status       = status;
        push_desc.offset       = fw_reg[12:0];
        push_desc.mf           = fw_reg[13];
        push_desc.df           = fw_reg[14];
        push_desc.total_length = tl_reg;
        push_desc.hw           = hw_c;
        push_desc.rhw          = rhw_c;
        push_desc.datalen      = datalen;
        push_desc.piece        = piece;
    end

endmodule

/* rtl/core/ipfp_queue.sv */
module ipfp_queue
    import ipfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  ipfp_desc_t push_desc,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output ipfp_desc_t pop_desc
);

    ipfp_desc_t             mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_desc  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    // occupancy bounded by depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy above depth");

    // a lone pop drops occupancy by one
    assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count not decremented on pop");

endmodule

/* rtl/core/ipfp_back.sv */
module ipfp_back
    import ipfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        desc_valid,
    input  ipfp_desc_t  desc,
    output logic        pop,
    output logic        result_valid,
    output logic [1:0]  status,
    output logic [12:0] fragment_offset,
    output logic        more_fragments,
    output logic        dont_fragment,
    output logic [15:0] fragment_length,
    output logic [3:0]  fragment_header_words,
    output logic [15:0] payload_start,
    output logic        last
);

    logic        active_reg;
    ipfp_desc_t  cur_reg;
    logic [15:0] rem_reg;
    logic [15:0] pos_reg;
    logic [3:0]  cur_hw_reg;

    logic        res_valid_reg;
    logic [1:0]  res_status_reg;
    logic [12:0] res_offset_reg;
    logic        res_mf_reg;
    logic        res_df_reg;
    logic [15:0] res_len_reg;
    logic [3:0]  res_hw_reg;
    logic [15:0] res_start_reg;
    logic        res_last_reg;

    logic        is_frag;
    logic [15:0] take;
    logic [15:0] rem_after;
    logic        finish;
    logic [1:0]  res_status_next;
    logic [12:0] res_offset_next;
    logic        res_mf_next;
    logic        res_df_next;
    logic [15:0] res_len_next;
    logic [3:0]  res_hw_next;
    logic [15:0] res_start_next;
    logic        res_last_next;

    always_comb
    begin
        is_frag   = (cur_reg.status == ST_FRAG);
        take      = (rem_reg > cur_reg.piece) ? cur_reg.piece : rem_reg;
        rem_after = rem_reg - take;
        finish    = active_reg && (!is_frag || (rem_after == '0));
        pop       = desc_valid && (!active_reg || finish);

        if (is_frag)
        begin
            res_status_next = ST_FRAG;
            res_offset_next = cur_reg.offset + pos_reg[15:3];
            res_mf_next     = (rem_after != '0) ? 1'b1 : cur_reg.mf;
            res_df_next     = 1'b0;
            res_len_next    = {10'd0, cur_hw_reg, 2'b00} + take;
            res_hw_next     = cur_hw_reg;
            res_start_next  = pos_reg;
            res_last_next   = (rem_after == '0);
        end
        else
        begin
            res_status_next = cur_reg.status;
            res_offset_next = cur_reg.offset;
            res_mf_next     = cur_reg.mf;
            res_df_next     = cur_reg.df;
            res_len_next    = cur_reg.total_length;
            res_hw_next     = cur_reg.hw;
            res_start_next  = '0;
            res_last_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= active_reg;
            if (pop)
            begin
                active_reg <= 1'b1;
            end
            else if (finish)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg    <= desc;
            rem_reg    <= desc.datalen;
            pos_reg    <= '0;
            cur_hw_reg <= desc.hw;
        end
        else if (active_reg)
        begin
            rem_reg <= rem_after;
            pos_reg <= pos_reg + take;
            if ((pos_reg == '0) && (cur_reg.hw > MIN_HDR_WORDS))
            begin
                cur_hw_reg <= cur_reg.rhw;
            end
        end
        if (active_reg)
        begin
            res_status_reg <= res_status_next;
            res_offset_reg <= res_offset_next;
            res_mf_reg     <= res_mf_next;
            res_df_reg     <= res_df_next;
            res_len_reg    <= res_len_next;
            res_hw_reg     <= res_hw_next;
            res_start_reg  <= res_start_next;
            res_last_reg   <= res_last_next;
        end
    end

    assign result_valid          = res_valid_reg;
    assign status                = res_status_reg;
    assign fragment_offset       = res_offset_reg;
    assign more_fragments        = res_mf_reg;
    assign dont_fragment         = res_df_reg;
    assign fragment_length       = res_len_reg;
    assign fragment_header_words = res_hw_reg;
    assign payload_start         = res_start_reg;
    assign last                  = res_last_reg;

    // pass and error results stand alone
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != ST_FRAG) |-> last)
        else $error("single result without last");

    // a fragment train has no gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> result_valid && (status == ST_FRAG))
        else $error("fragment train interrupted");

    // every fragment but the final one carries MF
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> more_fragments)
        else $error("inner fragment without MF");

    // train continues at the next payload position
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> payload_start > $past(payload_start))
        else $error("payload position not advancing");

endmodule

/* rtl/core/ip_fragment_planner_top.sv */
// ipv4 fragmentation planner: for each datagram header transaction (start while busy is low)
// the block emits either one result (pass-through, DF blocked or offset or fragment-count
// overflow, status 0/2/3) or one result per outgoing fragment (status 1), the final one
// flagged by last. results appear for exactly one cycle each while result_valid is high
// and cannot be held off, so the receiver must take one result per cycle. a fragment train
// comes out on consecutive cycles with no gaps. from idle, a transaction's first result
// passes the input register, the queue, the engine register and the result register. the
// fragment engine produces one result per cycle while it holds a datagram; the input side
// takes a new transaction every cycle until the two-entry classification queue and the
// input register are full, after which busy rises and admission follows the engine's pace.
// mtu_bytes is loaded via cfg_write_en and cfg_write_data; the user must load it only while
// the block is idle, which the block itself does not enforce; values below 1088 act as 1088.
module ip_fragment_planner_top
    import ipfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    // input transaction
    input  logic        start,
    output logic        busy,
    input  logic [15:0] total_length,
    input  logic [3:0]  header_words,
    input  logic [15:0] frag_word,
    input  logic [3:0]  reduced_header_words,
    // result transaction
    output logic        result_valid,
    output logic [1:0]  status,
    output logic [12:0] fragment_offset,
    output logic        more_fragments,
    output logic        dont_fragment,
    output logic [15:0] fragment_length,
    output logic [3:0]  fragment_header_words,
    output logic [15:0] payload_start,
    output logic        last
);

    // front to queue
    logic       push;
    ipfp_desc_t push_desc;
    logic       queue_full;

    // queue to back
    logic       pop;
    logic       queue_not_empty;
    ipfp_desc_t pop_desc;

    // front: input register, mtu register and classification
    // (pass / df blocked / overflow / fragment, piece size, payload length)
    ipfp_front u_front
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_write_en         (cfg_write_en),
        .cfg_write_data       (cfg_write_data),
        .start                (start),
        .busy                 (busy),
        .total_length         (total_length),
        .header_words         (header_words),
        .frag_word            (frag_word),
        .reduced_header_words (reduced_header_words),
        .queue_full           (queue_full),
        .push                 (push),
        .push_desc            (push_desc)
    );

    // short decoupling queue of classified datagrams
    ipfp_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .pop_desc  (pop_desc)
    );

    // back: walks the payload one fragment per cycle into the result register
    ipfp_back u_back
    (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .desc_valid            (queue_not_empty),
        .desc                  (pop_desc),
        .pop                   (pop),
        .result_valid          (result_valid),
        .status                (status),
        .fragment_offset       (fragment_offset),
        .more_fragments        (more_fragments),
        .dont_fragment         (dont_fragment),
        .fragment_length       (fragment_length),
        .fragment_header_words (fragment_header_words),
        .payload_start         (payload_start),
        .last                  (last)
    );

endmodule
